[rtl/adti_pkg.sv]
// shared types, character codes and size limits for the ascii decimal to integer block
// no dependencies; used by every module under rtl
package adti_pkg;

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // target size codes (code three behaves as a word)
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // character count saturates here
    localparam logic [3:0] CNT_MAX = 4'd15;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEN  = 3'd1,
        ST_BAD_CHAR = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] character;
        logic [1:0] size_code;
        logic       signed_mode;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_result;

    // fold the unused code onto the word size
    function automatic logic [1:0] size_sel(input logic [1:0] code);
        return (code == 2'd3) ? SIZE_WORD : code;
    endfunction

    // unsigned maximum of a size
    function automatic logic [31:0] umax_of(input logic [1:0] sz);
        logic [31:0] m;
        unique case (sz)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_HALF: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // signed positive maximum of a size
    function automatic logic [31:0] smax_of(input logic [1:0] sz);
        logic [31:0] m;
        unique case (sz)
            SIZE_BYTE: m = 32'h0000_007F;
            SIZE_HALF: m = 32'h0000_7FFF;
            default:   m = 32'h7FFF_FFFF;
        endcase
        return m;
    endfunction

    // longest digit string of a size
    function automatic logic [3:0] max_len_of(input logic [1:0] sz);
        logic [3:0] n;
        unique case (sz)
            SIZE_BYTE: n = 4'd3;
            SIZE_HALF: n = 4'd5;
            default:   n = 4'd10;
        endcase
        return n;
    endfunction

endpackage

[rtl/adti_in_reg.sv]
// input register holding one character request ahead of the accumulator
// depends on adti_pkg for the item type
module adti_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  adti_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output adti_pkg::t_item o_item
);

    logic            r_valid;
    adti_pkg::t_item r_item;

    // free when empty or being drained this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/adti_core.sv]
// string state and per-character update: multiply by ten and add, flags, final status
// depends on adti_pkg for types, character codes and size limits
module adti_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  adti_pkg::t_item   i_item,
    output logic              o_emit,
    output adti_pkg::t_result o_result
);

    // string state
    logic [31:0] r_acc,      n_acc;
    logic        r_ovf,      n_ovf;
    logic        r_bad,      n_bad;
    logic [3:0]  r_count,    n_count;
    logic        r_neg,      n_neg;
    logic        r_at_start, n_at_start;
    logic [1:0]  r_fmt_size, n_fmt_size;
    logic        r_fmt_sgn,  n_fmt_sgn;

    logic [7:0]  ch;
    logic [1:0]  fmt_size;
    logic        fmt_sgn;
    logic        sign_lead;
    logic [1:0]  sz;
    logic [31:0] umax;
    logic [31:0] smax;
    logic [3:0]  max_len;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] nv;
    logic [32:0] neg_lim;
    logic [31:0] mag;

    assign ch     = i_item.character;
    assign o_emit = (ch == adti_pkg::CHAR_NUL);

    // format: taken from the request at the first character, latched after
    always_comb begin
        fmt_size  = r_at_start ? i_item.size_code   : r_fmt_size;
        fmt_sgn   = r_at_start ? i_item.signed_mode : r_fmt_sgn;
        sign_lead = r_at_start && fmt_sgn
                    && (ch == adti_pkg::CHAR_MINUS || ch == adti_pkg::CHAR_PLUS);
        sz        = adti_pkg::size_sel(fmt_size);
        umax      = adti_pkg::umax_of(sz);
        smax      = adti_pkg::smax_of(sz);
        max_len   = adti_pkg::max_len_of(sz);
    end

    // digit decode and value times ten plus digit
    always_comb begin
        is_digit = (ch >= adti_pkg::CHAR_ZERO) && (ch <= adti_pkg::CHAR_NINE);
        digit    = 4'(ch - adti_pkg::CHAR_ZERO);
        nv       = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {32'b0, digit};
    end

    // next state
    always_comb begin
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_bad      = r_bad;
        n_count    = r_count;
        n_neg      = r_neg;
        n_at_start = r_at_start;
        n_fmt_size = r_fmt_size;
        n_fmt_sgn  = r_fmt_sgn;
        if (i_fire) begin
            priority if (sign_lead) begin
                n_neg      = (ch == adti_pkg::CHAR_MINUS);
                n_at_start = 1'b0;
                n_fmt_size = fmt_size;
                n_fmt_sgn  = fmt_sgn;
            end else if (!o_emit) begin
                n_at_start = 1'b0;
                n_fmt_size = fmt_size;
                n_fmt_sgn  = fmt_sgn;
                if (r_count < adti_pkg::CNT_MAX) begin
                    n_count = r_count + 4'd1;
                end
                if (is_digit) begin
                    if (!r_ovf && !r_bad) begin
                        if (nv > {4'b0, umax}) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = nv[31:0];
                        end
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end else begin
                // end of string: back to the idle string state
                n_acc      = '0;
                n_ovf      = 1'b0;
                n_bad      = 1'b0;
                n_count    = '0;
                n_neg      = 1'b0;
                n_at_start = 1'b1;
                n_fmt_size = '0;
                n_fmt_sgn  = 1'b0;
            end
        end
    end

    // final status and value at the terminating nul
    always_comb begin
        neg_lim         = {1'b0, smax} + {32'b0, r_neg};
        mag             = r_neg ? (32'd0 - r_acc) : r_acc;
        o_result.value  = '0;
        priority if (r_count == 4'd0 || r_count > max_len) begin
            o_result.status = adti_pkg::ST_BAD_LEN;
        end else if (r_bad) begin
            o_result.status = adti_pkg::ST_BAD_CHAR;
        end else if (r_ovf) begin
            o_result.status = adti_pkg::ST_OVERFLOW;
        end else if (fmt_sgn && ({1'b0, r_acc} > neg_lim)) begin
            o_result.status = adti_pkg::ST_RANGE;
        end else begin
            o_result.status = adti_pkg::ST_OK;
            o_result.value  = mag & umax;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_bad      <= 1'b0;
            r_count    <= '0;
            r_neg      <= 1'b0;
            r_at_start <= 1'b1;
            r_fmt_size <= '0;
            r_fmt_sgn  <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_bad      <= n_bad;
            r_count    <= n_count;
            r_neg      <= n_neg;
            r_at_start <= n_at_start;
            r_fmt_size <= n_fmt_size;
            r_fmt_sgn  <= n_fmt_sgn;
        end
    end

    // a string between requests is fully cleared
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_start |-> (r_acc == 32'd0 && r_count == 4'd0 && !r_neg && !r_ovf && !r_bad))
        else $error("string state not clear at string start");

    // accumulator never exceeds the latched size
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_at_start |-> (r_acc <= adti_pkg::umax_of(adti_pkg::size_sel(r_fmt_size))))
        else $error("accumulator above size maximum");

    // the nul closes the string
    a_nul_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_emit) |=> r_at_start)
        else $error("state not returned to string start after nul");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_emit && o_result.status != adti_pkg::ST_OK) |-> (o_result.value == 32'd0))
        else $error("error result with nonzero value");

endmodule

[rtl/adti_out_reg.sv]
// result register holding one converted number until taken
// depends on adti_pkg for the result type
module adti_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  adti_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output adti_pkg::t_result o_result
);

    logic              r_valid;
    adti_pkg::t_result r_result;

    // room when empty or being taken this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/ascii_decimal_to_integer.sv]
// Converts an ASCII decimal string, one character per request and ended by a NUL, into a
// one, two or four byte integer, signed or unsigned, as chosen at the first character.
// One character is taken every clock cycle while the input does not stall; the result of a
// string is loaded into an output register when its NUL leaves the input register, so that
// characters keep flowing while a result waits; only a NUL that meets a full result
// register stalls the input. The rate rests on the combinational multiply-by-ten-and-add in the
// accumulator. Status: 0 ok, 1 bad length, 2 bad character, 3 overflow, 4 signed range;
// value is zero whenever status is not ok.
// top level; instantiates adti_in_reg, adti_core and adti_out_reg, uses adti_pkg
module ascii_decimal_to_integer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_character,
    input  logic [1:0]  i_size_code,
    input  logic        i_signed_mode,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic [2:0]  o_status
);

    adti_pkg::t_item   in_item;
    adti_pkg::t_item   stage_item;
    adti_pkg::t_result core_result;
    adti_pkg::t_result out_result;
    logic              stage_valid;
    logic              emit;
    logic              out_free;
    logic              advance;

    // request payload packing
    assign in_item.character   = i_character;
    assign in_item.size_code   = i_size_code;
    assign in_item.signed_mode = i_signed_mode;

    // a character moves on unless it is a nul facing a full result register
    assign advance = stage_valid && (!emit || out_free);

    adti_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (advance),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    adti_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (stage_item),
        .o_emit   (emit),
        .o_result (core_result)
    );

    adti_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    // result unpacking
    assign o_value  = out_result.value;
    assign o_status = out_result.status;

endmodule

[sim/ascii_decimal_to_integer_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for ascii_decimal_to_integer: random strings, gaps and stalls
// depends on rtl/adti_pkg.sv and rtl/ascii_decimal_to_integer.sv
module ascii_decimal_to_integer_tb;

    localparam int ITEM_TARGET  = 1550;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int LONG_HOLD_AT = 30;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_PRINTS   = 40;

    // spare size code, folded onto the word size by the block
    localparam logic [1:0] SIZE_SPARE = 2'd3;

    typedef struct {
        logic [7:0] ch;
        logic [1:0] code;
        logic       sm;
        int         gap;
        bit         drain;
    } t_char_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_character = '0;
    logic [1:0]  i_size_code = '0;
    logic        i_signed_mode = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_value;
    logic [2:0]  o_status;

    t_char_req         pending_chars[$];
    adti_pkg::t_result expected_conversions[$];
    logic [7:0]        str_buf[$];

    // sender and receiver bookkeeping
    bit        rst_done = 1'b0;
    bit        tx_taken = 1'b0;
    bit        rx_taken = 1'b0;
    bit        have_staged = 1'b0;
    bit        drain_next = 1'b0;
    bit        tx_burst = 1'b0;
    bit        rx_burst = 1'b0;
    t_char_req staged;
    int        rx_wait = 0;
    int        n_generated = 0;
    int        results_seen = 0;
    int        n_errors = 0;
    int        idle_cycles = 0;

    // predictor state
    logic [31:0] conv_acc = '0;
    bit          conv_overflow = 1'b0;
    bit          conv_bad_char = 1'b0;
    logic [3:0]  conv_count = '0;
    bit          conv_negative = 1'b0;
    bit          conv_at_start = 1'b1;
    logic [1:0]  conv_code = '0;
    bit          conv_signed = 1'b0;

    ascii_decimal_to_integer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_character   (i_character),
        .i_size_code   (i_size_code),
        .i_signed_mode (i_signed_mode),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value       (o_value),
        .o_status      (o_status)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("mismatch %0s: got %0h want %0h (result %0d, t=%0t)",
                     what, got, want, results_seen, $realtime);
    endtask

    // one character through the converter, queueing the result at a NUL
    task automatic convert_char(input logic [7:0] ch, input logic [1:0] code, input logic sm);
        longint unsigned   umax;
        longint unsigned   smax;
        longint unsigned   next_val;
        logic [3:0]        max_len;
        adti_pkg::t_result res;
        if (conv_at_start) begin
            conv_code = code;
            conv_signed = sm;
            conv_at_start = 1'b0;
            if (sm && (ch == adti_pkg::CHAR_MINUS || ch == adti_pkg::CHAR_PLUS)) begin
                conv_negative = (ch == adti_pkg::CHAR_MINUS);
                return;
            end
        end
        case (conv_code)
            adti_pkg::SIZE_BYTE: begin
                umax = 64'hFF;
                smax = 64'h7F;
                max_len = 4'd3;
            end
            adti_pkg::SIZE_HALF: begin
                umax = 64'hFFFF;
                smax = 64'h7FFF;
                max_len = 4'd5;
            end
            default: begin
                umax = 64'hFFFF_FFFF;
                smax = 64'h7FFF_FFFF;
                max_len = 4'd10;
            end
        endcase
        if (ch != adti_pkg::CHAR_NUL) begin
            if (conv_count != adti_pkg::CNT_MAX)
                conv_count++;
            if (ch >= adti_pkg::CHAR_ZERO && ch <= adti_pkg::CHAR_NINE) begin
                // accumulator freezes once overflow or a bad character is seen
                if (!conv_overflow && !conv_bad_char) begin
                    next_val = 64'(conv_acc);
                    next_val = next_val * 10 + 64'(ch - adti_pkg::CHAR_ZERO);
                    if (next_val > umax)
                        conv_overflow = 1'b1;
                    else
                        conv_acc = next_val[31:0];
                end
            end else begin
                conv_bad_char = 1'b1;
            end
            return;
        end
        // end of string: status in priority order
        res.value = '0;
        if (conv_count == 0 || conv_count > max_len)
            res.status = adti_pkg::ST_BAD_LEN;
        else if (conv_bad_char)
            res.status = adti_pkg::ST_BAD_CHAR;
        else if (conv_overflow)
            res.status = adti_pkg::ST_OVERFLOW;
        else if (conv_signed && 64'(conv_acc) > smax + 64'(conv_negative))
            res.status = adti_pkg::ST_RANGE;
        else begin
            res.status = adti_pkg::ST_OK;
            res.value = (conv_negative ? (32'd0 - conv_acc) : conv_acc) & umax[31:0];
        end
        expected_conversions.push_back(res);
        conv_acc = '0;
        conv_overflow = 1'b0;
        conv_bad_char = 1'b0;
        conv_count = '0;
        conv_negative = 1'b0;
        conv_at_start = 1'b1;
        conv_code = '0;
        conv_signed = 1'b0;
    endtask

    // queue the buffered string plus its NUL; only the first request carries the format
    task automatic push_string(input logic [1:0] code, input logic sm);
        t_char_req r;
        str_buf.push_back(adti_pkg::CHAR_NUL);
        foreach (str_buf[i]) begin
            r.ch = str_buf[i];
            r.code = (i == 0) ? code : 2'($urandom_range(0, 3));
            r.sm = (i == 0) ? sm : 1'($urandom_range(0, 1));
            r.gap = tx_burst ? 0 : int'($urandom_range(0, 9));
            r.drain = (i == 0) && drain_next;
            pending_chars.push_back(r);
        end
        n_generated += str_buf.size();
        drain_next = 1'b0;
        str_buf.delete();
    endtask

    task automatic directed_string(input string s, input logic [1:0] code, input logic sm);
        for (int i = 0; i < s.len(); i++)
            str_buf.push_back(s[i]);
        push_string(code, sm);
    endtask

    task automatic append_number(input longint unsigned mag, input int zeros);
        logic [7:0] digits[$];
        repeat (zeros) str_buf.push_back(adti_pkg::CHAR_ZERO);
        do begin
            digits.push_front(adti_pkg::CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        foreach (digits[i])
            str_buf.push_back(digits[i]);
    endtask

    task automatic append_digits(input int n);
        repeat (n) str_buf.push_back(adti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic random_string();
        logic [1:0]      code;
        logic            sm;
        longint unsigned umax;
        longint unsigned smax;
        longint unsigned mag;
        longint unsigned span;
        int              max_len;
        int              kind;
        int              n;
        int              pos;
        int              sign_sel;
        logic [7:0]      odd;
        code = 2'($urandom_range(0, 3));
        sm = 1'($urandom_range(0, 1));
        case (code)
            adti_pkg::SIZE_BYTE: begin
                umax = 64'hFF;
                smax = 64'h7F;
                max_len = 3;
            end
            adti_pkg::SIZE_HALF: begin
                umax = 64'hFFFF;
                smax = 64'h7FFF;
                max_len = 5;
            end
            default: begin
                umax = 64'hFFFF_FFFF;
                smax = 64'h7FFF_FFFF;
                max_len = 10;
            end
        endcase
        kind = int'($urandom_range(0, 19));
        if (kind < 12) begin
            // well-formed number, often near a range edge
            if (sm) begin
                sign_sel = int'($urandom_range(0, 2));
                if (sign_sel == 1)
                    str_buf.push_back(adti_pkg::CHAR_MINUS);
                else if (sign_sel == 2)
                    str_buf.push_back(adti_pkg::CHAR_PLUS);
            end
            case ($urandom_range(0, 4))
                0: mag = 64'($urandom_range(0, 9));
                1: mag = smax - 1 + 64'($urandom_range(0, 3));
                2: mag = umax - 1 + 64'($urandom_range(0, 2));
                3: begin
                    span = 1;
                    repeat (max_len) span = span * 10;
                    mag = {$urandom, $urandom} % span;
                end
                default: mag = {$urandom, $urandom} & umax;
            endcase
            append_number(mag, ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 2)) : 0);
        end else if (kind < 14) begin
            // too many characters, past the count saturation too
            append_digits(int'($urandom_range(max_len + 1, 17)));
        end else if (kind < 16) begin
            // one stray non-digit somewhere in the digits
            n = int'($urandom_range(1, max_len));
            pos = int'($urandom_range(0, n - 1));
            do
                odd = 8'($urandom_range(1, 255));
            while (odd >= adti_pkg::CHAR_ZERO && odd <= adti_pkg::CHAR_NINE);
            for (int i = 0; i < n; i++) begin
                if (i == pos)
                    str_buf.push_back(odd);
                else
                    append_digits(1);
            end
        end else if (kind == 16) begin
            // sign where it is not allowed
            if (sm)
                append_digits(int'($urandom_range(1, 2)));
            str_buf.push_back($urandom_range(0, 1) ? adti_pkg::CHAR_MINUS : adti_pkg::CHAR_PLUS);
            append_digits(int'($urandom_range(0, 2)));
        end else if (kind == 17) begin
            // empty string or a lone sign
            if (sm && $urandom_range(0, 1))
                str_buf.push_back($urandom_range(0, 1) ? adti_pkg::CHAR_MINUS
                                                       : adti_pkg::CHAR_PLUS);
        end else begin
            // noise bytes
            repeat ($urandom_range(1, 6)) str_buf.push_back(8'($urandom_range(1, 255)));
        end
        push_string(code, sm);
    endtask

    // request driver: one request at a time, after its drawn gap
    always @(negedge i_clk) begin : char_source
        if (rst_done && !(i_valid && !tx_taken)) begin
            tx_taken = 1'b0;
            if (!have_staged && pending_chars.size() != 0) begin
                staged = pending_chars.pop_front();
                have_staged = 1'b1;
            end
            if (!have_staged) begin
                i_valid <= 1'b0;
            end else if (staged.drain && expected_conversions.size() != 0) begin
                // hold back until every queued result has been returned
                i_valid <= 1'b0;
            end else if (staged.gap > 0) begin
                staged.gap = staged.gap - 1;
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_character <= staged.ch;
                i_size_code <= staged.code;
                i_signed_mode <= staged.sm;
                have_staged = 1'b0;
            end
        end
    end

    // result sink: random stalls, bursts, and one long hold-off
    always @(negedge i_clk) begin : result_sink
        if (rst_done) begin
            if (rx_taken) begin
                rx_taken = 1'b0;
                if (results_seen == LONG_HOLD_AT)
                    rx_wait = LONG_HOLD;
                else
                    rx_wait = rx_burst ? 0 : int'($urandom_range(0, 9));
                if ($urandom_range(0, 49) == 0)
                    rx_burst = !rx_burst;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_ready <= (rx_wait == 0);
        end
    end

    // handshake monitor: checks results, predicts on accepted requests, watchdog
    always @(posedge i_clk) begin : handshake_monitor
        adti_pkg::t_result want;
        bit                moved;
        moved = 1'b0;
        if (rst_done) begin
            if (o_valid && i_ready) begin
                moved = 1'b1;
                rx_taken = 1'b1;
                if (expected_conversions.size() == 0) begin
                    report_mismatch("unexpected result", o_value, '0);
                end else begin
                    want = expected_conversions.pop_front();
                    if (o_value !== want.value)
                        report_mismatch("value", o_value, want.value);
                    if (o_status !== want.status)
                        report_mismatch("status", {29'd0, o_status}, {29'd0, want.status});
                end
                results_seen++;
            end
            if (i_valid && o_ready) begin
                moved = 1'b1;
                tx_taken = 1'b1;
                convert_char(i_character, i_size_code, i_signed_mode);
            end
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ascii_decimal_to_integer regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n_strings;
        // directed strings
        directed_string("", adti_pkg::SIZE_BYTE, 1'b0);
        directed_string("-", adti_pkg::SIZE_BYTE, 1'b1);
        directed_string("-128", adti_pkg::SIZE_BYTE, 1'b1);
        directed_string("256", adti_pkg::SIZE_BYTE, 1'b0);
        directed_string("-0", adti_pkg::SIZE_HALF, 1'b1);
        directed_string("+5", adti_pkg::SIZE_BYTE, 1'b0);
        directed_string("1-", adti_pkg::SIZE_HALF, 1'b1);
        directed_string("4294967295", SIZE_SPARE, 1'b0);
        // random strings, with a drained pause at the start and midway
        n_strings = 0;
        drain_next = 1'b1;
        while (n_generated < ITEM_TARGET) begin
            if (n_strings == 120)
                drain_next = 1'b1;
            if ($urandom_range(0, 29) == 0)
                tx_burst = !tx_burst;
            random_string();
            n_strings++;
        end

        // reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // run out the requests, then the results
        while (pending_chars.size() != 0 || have_staged || i_valid)
            @(posedge i_clk);
        while (expected_conversions.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("ascii_decimal_to_integer regression: pass");
        else
            $display("ascii_decimal_to_integer regression: fail");
        $finish;
    end

endmodule

[files.f]
rtl/adti_pkg.sv
rtl/adti_in_reg.sv
rtl/adti_core.sv
rtl/adti_out_reg.sv
rtl/ascii_decimal_to_integer.sv
sim/ascii_decimal_to_integer_tb.sv
